// ===== rtl/sfbs_pkg.sv =====
package sfbs_pkg;

  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned STEPS_W = 15;
  localparam int unsigned TINT_W  = 8;
  localparam int unsigned QUO_W   = 16;
  localparam int unsigned CNT_W   = 4;

  localparam logic signed [LEVEL_W-1:0] NEUTRAL_LEVEL = 16'sh0100;

  // operation codes carried on in_tuser
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // blend kind carried on out_tuser
  localparam logic BLEND_ADD = 1'b0;
  localparam logic BLEND_SUB = 1'b1;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DSTART,
    ST_DITER,
    ST_DDONE,
    ST_FINISH
  } state_t;

endpackage

// ===== rtl/screen_fade_blend_stepper_core.sv =====
// Screen fade stepper. A load transaction (in_tuser = 1) stores a target
// colour and a step count, and the block stays ready. A tick transaction
// (in_tuser = 0) moves the current colour one step toward the target and,
// unless the colour is neutral (all channels 256), emits one blend-tile
// transaction. With steps left, each of the three channels goes through one
// shared radix-2 restoring divider (a set-up step, one step per quotient bit
// for all 16 quotient bits, an update step), then the tint is formed. With no
// steps left the colour snaps to the target before the tint is formed. The
// input is not ready while a tick is in progress; a finished result waits in
// the output register, and a tick stalls at its end only if the previous
// result has not yet been taken.
module screen_fade_blend_stepper_core
  import sfbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] new_red, [31:16] new_green, [47:32] new_blue, [62:48] new_steps,
  // [63] zero
  input  logic [63:0] in_tdata,
  // [0] operation
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] tint_red, [15:8] tint_green, [23:16] tint_blue
  output logic [23:0] out_tdata,
  // [0] blend_subtract
  output logic        out_tuser
);

  state_t state_r, state_nxt;
  chan_t  ch_r, ch_nxt;

  logic signed [LEVEL_W-1:0] tgt_red_r, tgt_green_r, tgt_blue_r;
  logic signed [LEVEL_W-1:0] tgt_red_nxt, tgt_green_nxt, tgt_blue_nxt;
  logic signed [LEVEL_W-1:0] cur_red_r, cur_green_r, cur_blue_r;
  logic signed [LEVEL_W-1:0] cur_red_nxt, cur_green_nxt, cur_blue_nxt;
  logic [STEPS_W-1:0]        steps_r, steps_nxt;

  logic [QUO_W-1:0]   quo_r, quo_nxt;
  logic [STEPS_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               neg_r, neg_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [23:0] out_data_r, out_data_nxt;
  logic        out_sub_r, out_sub_nxt;

  logic                      in_acc;
  logic                      slot_free;
  logic signed [LEVEL_W-1:0] cur_sel, tgt_sel;
  logic signed [LEVEL_W:0]   diff;
  logic [LEVEL_W:0]          diff_mag;
  logic [QUO_W-1:0]          shift_w;
  logic [QUO_W:0]            trial;
  logic                      trial_ge;
  logic [LEVEL_W-1:0]        delta;
  logic signed [LEVEL_W-1:0] cur_upd;
  logic                      neutral;

  function automatic logic [TINT_W-1:0] sub_tint(input logic signed [LEVEL_W-1:0] lvl);
    logic [TINT_W-1:0] res;
    if (lvl == NEUTRAL_LEVEL) begin
      res = '0;
    end else begin
      res = ~lvl[TINT_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [TINT_W-1:0] add_tint(input logic signed [LEVEL_W-1:0] lvl);
    logic [LEVEL_W-1:0] m1;
    m1 = lvl - LEVEL_W'(1);
    return m1[TINT_W-1:0];
  endfunction

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign slot_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sub_r;

  always_comb begin
    case (ch_r)
      CH_RED:   begin cur_sel = cur_red_r;   tgt_sel = tgt_red_r;   end
      CH_GREEN: begin cur_sel = cur_green_r; tgt_sel = tgt_green_r; end
      default:  begin cur_sel = cur_blue_r;  tgt_sel = tgt_blue_r;  end
    endcase
  end

  // shared divider step and operand preparation
  assign diff     = {tgt_sel[LEVEL_W-1], tgt_sel} - {cur_sel[LEVEL_W-1], cur_sel};
  assign diff_mag = diff[LEVEL_W] ? (LEVEL_W+1)'(0) - diff : diff;
  assign shift_w  = {rem_r, quo_r[QUO_W-1]};
  assign trial    = {1'b0, shift_w} - {2'b00, steps_r};
  assign trial_ge = !trial[QUO_W];
  assign delta    = neg_r ? QUO_W'(0) - quo_r : quo_r;
  assign cur_upd  = cur_sel + delta;

  assign neutral = (cur_red_r == NEUTRAL_LEVEL) && (cur_green_r == NEUTRAL_LEVEL) &&
                   (cur_blue_r == NEUTRAL_LEVEL);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tuser == OP_TICK) begin
          state_nxt = (steps_r != '0) ? ST_DSTART : ST_FINISH;
        end
      end
      ST_DSTART: state_nxt = ST_DITER;
      ST_DITER: begin
        if (cnt_r == CNT_W'(QUO_W - 1)) begin
          state_nxt = ST_DDONE;
        end
      end
      ST_DDONE: state_nxt = (ch_r == CH_BLUE) ? ST_FINISH : ST_DSTART;
      ST_FINISH: begin
        if (neutral || slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    ch_nxt        = ch_r;
    tgt_red_nxt   = tgt_red_r;
    tgt_green_nxt = tgt_green_r;
    tgt_blue_nxt  = tgt_blue_r;
    cur_red_nxt   = cur_red_r;
    cur_green_nxt = cur_green_r;
    cur_blue_nxt  = cur_blue_r;
    steps_nxt     = steps_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_sub_nxt   = out_sub_r;
    unique case (state_r)
      ST_IDLE: begin
        ch_nxt = CH_RED;
        if (in_acc) begin
          if (in_tuser == OP_LOAD) begin
            tgt_red_nxt   = in_tdata[15:0];
            tgt_green_nxt = in_tdata[31:16];
            tgt_blue_nxt  = in_tdata[47:32];
            steps_nxt     = in_tdata[62:48];
          end else if (steps_r == '0) begin
            // snap to target
            cur_red_nxt   = tgt_red_r;
            cur_green_nxt = tgt_green_r;
            cur_blue_nxt  = tgt_blue_r;
          end
        end
      end
      ST_DSTART: begin
        neg_nxt = diff[LEVEL_W];
        quo_nxt = diff_mag[QUO_W-1:0];
        rem_nxt = '0;
        cnt_nxt = '0;
      end
      ST_DITER: begin
        rem_nxt = trial_ge ? trial[STEPS_W-1:0] : shift_w[STEPS_W-1:0];
        quo_nxt = {quo_r[QUO_W-2:0], trial_ge};
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      ST_DDONE: begin
        case (ch_r)
          CH_RED:   cur_red_nxt   = cur_upd;
          CH_GREEN: cur_green_nxt = cur_upd;
          default:  cur_blue_nxt  = cur_upd;
        endcase
        if (ch_r == CH_BLUE) begin
          steps_nxt = steps_r - STEPS_W'(1);
        end else begin
          ch_nxt = chan_t'(ch_r + 2'd1);
        end
      end
      ST_FINISH: begin
        if (!neutral && slot_free) begin
          out_valid_nxt = 1'b1;
          if (cur_red_r > NEUTRAL_LEVEL) begin
            out_data_nxt = {add_tint(cur_blue_r), add_tint(cur_green_r),
                            add_tint(cur_red_r)};
            out_sub_nxt  = BLEND_ADD;
          end else begin
            out_data_nxt = {sub_tint(cur_blue_r), sub_tint(cur_green_r),
                            sub_tint(cur_red_r)};
            out_sub_nxt  = BLEND_SUB;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= CH_RED;
      tgt_red_r   <= NEUTRAL_LEVEL;
      tgt_green_r <= NEUTRAL_LEVEL;
      tgt_blue_r  <= NEUTRAL_LEVEL;
      cur_red_r   <= NEUTRAL_LEVEL;
      cur_green_r <= NEUTRAL_LEVEL;
      cur_blue_r  <= NEUTRAL_LEVEL;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      tgt_red_r   <= tgt_red_nxt;
      tgt_green_r <= tgt_green_nxt;
      tgt_blue_r  <= tgt_blue_nxt;
      cur_red_r   <= cur_red_nxt;
      cur_green_r <= cur_green_nxt;
      cur_blue_r  <= cur_blue_nxt;
      steps_r     <= steps_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    neg_r      <= neg_nxt;
    out_data_r <= out_data_nxt;
    out_sub_r  <= out_sub_nxt;
  end

endmodule

// ===== rtl/sfbs_checker.sv =====
module sfbs_checker
  import sfbs_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // after a load the block is ready again in the next cycle
  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_LOAD |=> in_tready)
    else $error("not ready after a load");

  // a tick always occupies the block
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_TICK |=> !in_tready)
    else $error("ready straight after a tick");

  // a new result only appears at the end of a tick
  a_out_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result raised while idle");

endmodule

bind screen_fade_blend_stepper_core sfbs_checker u_sfbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== bench/tb_screen_fade_blend_stepper_core.sv =====
`timescale 1ns / 1ps
module tb_screen_fade_blend_stepper_core;
  import sfbs_pkg::*;

  typedef struct packed {
    logic                      op;
    logic signed [LEVEL_W-1:0] red;
    logic signed [LEVEL_W-1:0] green;
    logic signed [LEVEL_W-1:0] blue;
    logic [STEPS_W-1:0]        steps;
  } fade_cmd_t;

  typedef struct packed {
    logic [TINT_W-1:0] red;
    logic [TINT_W-1:0] green;
    logic [TINT_W-1:0] blue;
    logic              kind;
  } blend_tile_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic        in_tuser   = OP_TICK;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;

  fade_cmd_t   fade_queue [$];
  blend_tile_t tile_expect [$];
  fade_cmd_t   cmd_on_bus;
  int          gap_left   = 0;
  int          stall_left = 0;
  int          mismatches = 0;
  int          tiles_seen = 0;
  bit          calm       = 1'b0;

  // predicted fade state
  logic signed [LEVEL_W-1:0] goal_lvl  [3];
  logic signed [LEVEL_W-1:0] shade_lvl [3];
  logic [LEVEL_W-1:0]        steps_to_go;

  screen_fade_blend_stepper_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  function automatic void clear_fade();
    for (int i = 0; i < 3; i++) begin
      goal_lvl[i]  = NEUTRAL_LEVEL;
      shade_lvl[i] = NEUTRAL_LEVEL;
    end
    steps_to_go = '0;
  endfunction

  task automatic advance_fade(input fade_cmd_t c);
    int          diff;
    int          stride;
    blend_tile_t t;
    logic [LEVEL_W-1:0] lv [3];
    if (c.op == OP_LOAD) begin
      goal_lvl[0] = c.red;
      goal_lvl[1] = c.green;
      goal_lvl[2] = c.blue;
      steps_to_go = {1'b0, c.steps};
    end else begin
      if (steps_to_go != 0) begin
        stride = int'(steps_to_go);
        for (int i = 0; i < 3; i++) begin
          diff = int'(goal_lvl[i]) - int'(shade_lvl[i]);
          shade_lvl[i] = LEVEL_W'(int'(shade_lvl[i]) + diff / stride);
        end
        steps_to_go = steps_to_go - 1'b1;
      end else begin
        for (int i = 0; i < 3; i++) shade_lvl[i] = goal_lvl[i];
      end
      if (!(shade_lvl[0] == NEUTRAL_LEVEL && shade_lvl[1] == NEUTRAL_LEVEL &&
            shade_lvl[2] == NEUTRAL_LEVEL)) begin
        for (int i = 0; i < 3; i++) begin
          if (shade_lvl[0] > NEUTRAL_LEVEL)
            lv[i] = shade_lvl[i] - 16'sd1;
          else if (shade_lvl[i] == NEUTRAL_LEVEL)
            lv[i] = '0;
          else
            lv[i] = ~shade_lvl[i];
        end
        t.red   = lv[0][TINT_W-1:0];
        t.green = lv[1][TINT_W-1:0];
        t.blue  = lv[2][TINT_W-1:0];
        t.kind  = (shade_lvl[0] > NEUTRAL_LEVEL) ? BLEND_ADD : BLEND_SUB;
        tile_expect.push_back(t);
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_tile();
    blend_tile_t want;
    tiles_seen++;
    if (tile_expect.size() == 0) begin
      report_mismatch($sformatf("tile %0d (data %h, user %b) with none pending",
                                tiles_seen, out_tdata, out_tuser));
    end else begin
      want = tile_expect.pop_front();
      if (out_tdata[7:0] !== want.red)
        report_mismatch($sformatf("tile %0d tint_red %h, want %h",
                                  tiles_seen, out_tdata[7:0], want.red));
      if (out_tdata[15:8] !== want.green)
        report_mismatch($sformatf("tile %0d tint_green %h, want %h",
                                  tiles_seen, out_tdata[15:8], want.green));
      if (out_tdata[23:16] !== want.blue)
        report_mismatch($sformatf("tile %0d tint_blue %h, want %h",
                                  tiles_seen, out_tdata[23:16], want.blue));
      if (out_tuser !== want.kind)
        report_mismatch($sformatf("tile %0d blend_subtract %b, want %b",
                                  tiles_seen, out_tuser, want.kind));
    end
  endtask

  // mostly short gaps, now and then a long one; none while calm
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  function automatic logic signed [LEVEL_W-1:0] pick_level();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return LEVEL_W'(int'(NEUTRAL_LEVEL) + int'($urandom_range(0, 64)) - 32);
    if (r < 7) return LEVEL_W'($urandom_range(0, 511));
    if (r < 9) return LEVEL_W'($urandom);
    case ($urandom_range(0, 3))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return NEUTRAL_LEVEL;
      default: return 16'sh0000;
    endcase
  endfunction

  function automatic logic [STEPS_W-1:0] pick_steps();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return '0;
    if (r < 8) return STEPS_W'($urandom_range(1, 8));
    if (r < 9) return STEPS_W'($urandom_range(9, 40));
    return STEPS_W'($urandom);
  endfunction

  function automatic fade_cmd_t make_cmd(input logic op,
                                         input logic signed [LEVEL_W-1:0] r,
                                         input logic signed [LEVEL_W-1:0] g,
                                         input logic signed [LEVEL_W-1:0] b,
                                         input logic [STEPS_W-1:0] s);
    fade_cmd_t c;
    c.op    = op;
    c.red   = r;
    c.green = g;
    c.blue  = b;
    c.steps = s;
    return c;
  endfunction

  function automatic fade_cmd_t random_tick();
    return make_cmd(OP_TICK, LEVEL_W'($urandom), LEVEL_W'($urandom), LEVEL_W'($urandom),
                    STEPS_W'($urandom));
  endfunction

  // mostly a load followed by enough ticks to run out a fade of up to ten steps; some noise
  task automatic queue_fades(input int count);
    fade_cmd_t c;
    int        n;
    while (count > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        fade_queue.push_back(make_cmd($urandom_range(0, 3) == 0 ? OP_LOAD : OP_TICK,
                                      LEVEL_W'($urandom), LEVEL_W'($urandom),
                                      LEVEL_W'($urandom), STEPS_W'($urandom)));
        count--;
      end else begin
        if ($urandom_range(0, 9) == 0)
          c = make_cmd(OP_LOAD, NEUTRAL_LEVEL, NEUTRAL_LEVEL, NEUTRAL_LEVEL, pick_steps());
        else
          c = make_cmd(OP_LOAD, pick_level(), pick_level(), pick_level(), pick_steps());
        fade_queue.push_back(c);
        n = (c.steps > 10 ? 10 : int'(c.steps)) + $urandom_range(0, 3);
        repeat (n) fade_queue.push_back(random_tick());
        count -= n + 1;
      end
    end
  endtask

  task automatic wait_drained();
    while (fade_queue.size() != 0 || in_tvalid || tile_expect.size() != 0)
      @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= OP_TICK;
      clear_fade();
    end else begin
      if (in_tvalid && in_tready) advance_fade(cmd_on_bus);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0 || fade_queue.size() == 0) begin
          in_tvalid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          cmd_on_bus = fade_queue.pop_front();
          in_tdata  <= {1'b0, cmd_on_bus.steps, cmd_on_bus.blue, cmd_on_bus.green,
                        cmd_on_bus.red};
          in_tuser  <= cmd_on_bus.op;
          in_tvalid <= 1'b1;
          gap_left = pick_gap();
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_tile();
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // tick straight after reset: neutral, nothing comes out
    fade_queue.push_back(random_tick());
    // snap to an additive tint, then to a subtractive one with neutral channels
    fade_queue.push_back(make_cmd(OP_LOAD, 16'sd300, NEUTRAL_LEVEL, NEUTRAL_LEVEL, 15'd0));
    fade_queue.push_back(random_tick());
    fade_queue.push_back(make_cmd(OP_LOAD, NEUTRAL_LEVEL, 16'sd100, NEUTRAL_LEVEL, 15'd0));
    fade_queue.push_back(random_tick());
    // extreme levels over a few steps, the last tick snapping
    fade_queue.push_back(make_cmd(OP_LOAD, 16'sh7fff, 16'sh8000, 16'sd257, 15'd3));
    repeat (4) fade_queue.push_back(random_tick());
    // longest fade, opposite extremes
    fade_queue.push_back(make_cmd(OP_LOAD, 16'sh8000, 16'sh7fff, 16'sd255, 15'h7fff));
    repeat (2) fade_queue.push_back(random_tick());
    fade_queue.push_back(make_cmd(OP_LOAD, 16'sd0, -16'sd1, 16'sd511, 15'd1));
    repeat (2) fade_queue.push_back(random_tick());
    // fade back to neutral
    fade_queue.push_back(make_cmd(OP_LOAD, NEUTRAL_LEVEL, NEUTRAL_LEVEL, NEUTRAL_LEVEL,
                                  15'd2));
    repeat (3) fade_queue.push_back(random_tick());
    fade_queue.push_back(make_cmd(OP_LOAD, 16'sd257, 16'sh5555, 16'shaaaa, 15'h2aaa));
    repeat (2) fade_queue.push_back(random_tick());
    wait_drained();
    queue_fades(150);
    wait_drained();
    calm = 1'b1;
    queue_fades(150);
    wait_drained();
    calm = 1'b0;
    queue_fades(130);
    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && tile_expect.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule
